// File: design/tra_pkg.sv
package tra_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef logic [33:0] base_arr_t [TABLE_ENTRIES];
  typedef logic [23:0] slope_arr_t [TABLE_ENTRIES];

  // Item descriptor after normalization, carried down the pipe
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic        pow2;
    logic [5:0]  lead;
    logic [30:0] mant;
  } meta_t;

  // Finished result item
  typedef struct packed {
    logic        valid;
    logic [6:0]  shift_amount;
    logic [32:0] coarse_value;
    logic [32:0] refined_value;
    logic [30:0] aligned_mantissa;
  } res_t;

  // Entries whose base gets +2 and slope gets -2
  function automatic logic is_adj(input int i);
    logic r;
    case (i)
      0, 2, 3, 4, 6, 7, 13, 15, 16, 17, 18, 22, 26, 28, 30, 31,
      33, 34, 35, 36, 39, 42, 45, 51, 53, 55, 56, 61, 64, 67, 68, 84,
      86, 87, 89, 90, 91, 95, 96, 109, 112, 116, 118, 124, 130, 134, 136, 141,
      157, 161, 167, 170, 175, 176, 183, 184, 186, 193, 194, 204, 210, 213, 217, 228,
      236, 239, 241, 242, 250, 255: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Shift-subtract quotient of a power of two by den, for table generation
  function automatic logic [63:0] pow2_quot(input int p, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], (k == p)};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic base_arr_t gen_base();
    base_arr_t r;
    logic [63:0] d;
    logic [63:0] a;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      d = 64'd513 + 64'(2 * i);
      a = pow2_quot(45, d) - (64'd1 << 35) + 64'd9;
      if (is_adj(i)) a = a + 64'd2;
      a = (a + 64'd1) >> 1;
      r[i] = a[33:0];
    end
    return r;
  endfunction

  function automatic slope_arr_t gen_slope();
    slope_arr_t r;
    logic [63:0] d;
    logic [63:0] b;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      d = 64'd513 + 64'(2 * i);
      b = pow2_quot(43, d * d) + 64'd1;
      if (is_adj(i)) b = b - 64'd2;
      b = (b + 64'd1) >> 1;
      r[i] = b[23:0];
    end
    return r;
  endfunction

  localparam base_arr_t  BASE_ROM  = gen_base();
  localparam slope_arr_t SLOPE_ROM = gen_slope();

endpackage

// File: design/tra_norm.sv
module tra_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         operand,
  output tra_pkg::meta_t      meta
);
  import tra_pkg::*;

  logic        v1_r;
  logic [63:0] mag_r;
  logic [63:0] mag_nxt;
  meta_t       meta_r;
  meta_t       meta_nxt;
  logic [5:0]  lead;
  logic [63:0] aligned;

  // Take the magnitude
  assign mag_nxt = operand[63] ? (64'd0 - operand) : operand;

  // Find the leading one and left-align the bits below it
  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag_r[i]) lead = 6'(i);
    end
    aligned = mag_r << (6'd63 - lead);
    meta_nxt.valid = v1_r;
    meta_nxt.zero  = (mag_r == 64'd0);
    meta_nxt.lead  = lead;
    meta_nxt.mant  = aligned[62:32];
    meta_nxt.pow2  = (aligned[62:32] == 31'd0);
  end

  // Advance valid bits and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      meta_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      meta_r.valid <= meta_nxt.valid;
    end
    if (en) begin
      mag_r <= mag_nxt;
      meta_r.zero <= meta_nxt.zero;
      meta_r.pow2 <= meta_nxt.pow2;
      meta_r.lead <= meta_nxt.lead;
      meta_r.mant <= meta_nxt.mant;
    end
  end

  assign meta = meta_r;

endmodule

// File: design/tra_interp.sv
module tra_interp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  tra_pkg::meta_t  meta,
  output tra_pkg::res_t   res
);
  import tra_pkg::*;

  // Lookup stage
  meta_t       m_l_r;
  logic [35:0] y0_l_r;
  logic [23:0] slope_l_r;
  logic [22:0] fd_l_r;
  logic        below_l_r;
  // First multiply
  meta_t       m_m1_r;
  logic [35:0] y0_m1_r;
  logic [46:0] s1_m1_r;
  logic [22:0] fd_m1_r;
  logic        below_m1_r;
  // Coarse add
  meta_t       m_a1_r;
  logic [35:0] y1_a1_r;
  logic [21:0] s1h_a1_r;
  logic [22:0] fd_a1_r;
  // Second multiply
  meta_t       m_m2_r;
  logic [35:0] y1_m2_r;
  logic [19:0] s2_m2_r;
  // Third multiply
  meta_t       m_m3_r;
  logic [35:0] y1_m3_r;
  logic [19:0] add_m3_r;
  // Output
  res_t        res_r;
  res_t        res_nxt;

  logic [IDX_W-1:0] idx;
  logic [22:0]      frac;
  logic             below;
  logic [26:0]      s1_top;
  logic [35:0]      y1_nxt;
  logic [44:0]      p2;
  logic [39:0]      p3;
  logic [35:0]      y2;

  assign idx   = meta.mant[30:23];
  assign frac  = meta.mant[22:0];
  assign below = ~frac[22];

  assign s1_top = s1_m1_r[46:20];
  always_comb begin
    if (below_m1_r) begin
      y1_nxt = y0_m1_r + 36'(s1_top);
    end else begin
      y1_nxt = y0_m1_r - 36'(s1_top) - 36'd1 + 36'(s1_m1_r[19:0] == 20'd0);
    end
  end

  assign p2 = s1h_a1_r * fd_a1_r;
  assign p3 = s2_m2_r * y1_m2_r[35:16];
  assign y2 = y1_m3_r + 36'(add_m3_r);

  // Pick the result, with zero and power-of-two overrides
  always_comb begin
    res_nxt.valid = m_m3_r.valid;
    res_nxt.aligned_mantissa = m_m3_r.mant;
    if (m_m3_r.zero) begin
      res_nxt.shift_amount  = '0;
      res_nxt.coarse_value  = '0;
      res_nxt.refined_value = '0;
    end else if (m_m3_r.pow2) begin
      res_nxt.shift_amount  = 7'd1 - 7'(m_m3_r.lead);
      res_nxt.coarse_value  = 33'h080000000;
      res_nxt.refined_value = 33'h080000000;
    end else begin
      res_nxt.shift_amount  = 7'd0 - 7'(m_m3_r.lead);
      res_nxt.coarse_value  = y1_m3_r[35:3];
      res_nxt.refined_value = y2[35:3];
    end
  end

  // Advance the valid bits and the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_l_r.valid  <= 1'b0;
      m_m1_r.valid <= 1'b0;
      m_a1_r.valid <= 1'b0;
      m_m2_r.valid <= 1'b0;
      m_m3_r.valid <= 1'b0;
      res_r.valid  <= 1'b0;
    end else if (en) begin
      m_l_r.valid  <= meta.valid;
      m_m1_r.valid <= m_l_r.valid;
      m_a1_r.valid <= m_m1_r.valid;
      m_m2_r.valid <= m_a1_r.valid;
      m_m3_r.valid <= m_m2_r.valid;
      res_r.valid  <= res_nxt.valid;
    end
    if (en) begin
      {m_l_r.zero, m_l_r.pow2, m_l_r.lead, m_l_r.mant} <=
        {meta.zero, meta.pow2, meta.lead, meta.mant};
      y0_l_r    <= {2'b00, BASE_ROM[idx]} + 36'h400000000;
      slope_l_r <= SLOPE_ROM[idx];
      fd_l_r    <= below ? (23'h400000 - frac) : (frac - 23'h400000);
      below_l_r <= below;

      {m_m1_r.zero, m_m1_r.pow2, m_m1_r.lead, m_m1_r.mant} <=
        {m_l_r.zero, m_l_r.pow2, m_l_r.lead, m_l_r.mant};
      y0_m1_r    <= y0_l_r;
      s1_m1_r    <= slope_l_r * fd_l_r;
      fd_m1_r    <= fd_l_r;
      below_m1_r <= below_l_r;

      {m_a1_r.zero, m_a1_r.pow2, m_a1_r.lead, m_a1_r.mant} <=
        {m_m1_r.zero, m_m1_r.pow2, m_m1_r.lead, m_m1_r.mant};
      y1_a1_r  <= y1_nxt;
      s1h_a1_r <= s1_m1_r[46:25];
      fd_a1_r  <= fd_m1_r;

      {m_m2_r.zero, m_m2_r.pow2, m_m2_r.lead, m_m2_r.mant} <=
        {m_a1_r.zero, m_a1_r.pow2, m_a1_r.lead, m_a1_r.mant};
      y1_m2_r <= y1_a1_r;
      s2_m2_r <= p2[44:25];

      {m_m3_r.zero, m_m3_r.pow2, m_m3_r.lead, m_m3_r.mant} <=
        {m_m2_r.zero, m_m2_r.pow2, m_m2_r.lead, m_m2_r.mant};
      y1_m3_r  <= y1_m2_r;
      add_m3_r <= p3[39:20];

      res_r.shift_amount     <= res_nxt.shift_amount;
      res_r.coarse_value     <= res_nxt.coarse_value;
      res_r.refined_value    <= res_nxt.refined_value;
      res_r.aligned_mantissa <= res_nxt.aligned_mantissa;
    end
  end

  assign res = res_r;

endmodule

// File: design/table_reciprocal_approximation_top.sv
// Table-based reciprocal approximation, pipelined.
// Input channel: in_valid/in_ready carry a signed 64-bit in_operand; its
// magnitude is normalized, indexes a 256-entry base and slope table, and is
// interpolated through three chained multipliers.
// Result channel: out_valid/out_ready carry out_shift_amount, out_coarse_value,
// out_refined_value and out_aligned_mantissa, one result per item.
// Stages from acceptance to out_valid: magnitude, normalize, table lookup,
// first multiply, coarse add, second multiply, third multiply, final add.
// Throughput: one item per cycle while out_ready does not hold the pipe;
// each stage of the pipe holds at most one multiplier.
// Stall: while a result waits at the output and out_ready is low, the whole
// pipe holds and in_ready drops; nothing is lost or repeated. Empty stages
// upstream of a waiting result are not compressed.
// Reset: synchronous, active-low rst_n clears all valid bits; the block is
// ready to accept an item in the first cycle after reset.
module table_reciprocal_approximation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_shift_amount,
  output logic [32:0] out_coarse_value,
  output logic [32:0] out_refined_value,
  output logic [30:0] out_aligned_mantissa
);
  import tra_pkg::*;

  meta_t meta;
  res_t  res;
  logic  en;

  // Advance the pipe unless a finished item is held at the output
  assign en       = ~(res.valid & ~out_ready);
  assign in_ready = en;

  tra_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .operand  (in_operand),
    .meta     (meta)
  );

  tra_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .meta  (meta),
    .res   (res)
  );

  assign out_valid            = res.valid;
  assign out_shift_amount     = res.shift_amount;
  assign out_coarse_value     = res.coarse_value;
  assign out_refined_value    = res.refined_value;
  assign out_aligned_mantissa = res.aligned_mantissa;

endmodule
